// ===== sv/bae_pkg.sv =====
`timescale 1ns / 1ps
package bae_pkg;
  localparam int TRT_W = 16;  // treatment weight, Q8.8
  localparam int OUTC_W = 32; // outcome, Q16.16
  localparam int LBL_W = 16;  // confounder label
  localparam int EFF_W = 32;  // effect, Q16.16
  localparam int SU_W = 5;    // strata count on the result port
  localparam int WOS_W = 64;  // weighted outcome sum, Q40.24
  localparam int DVD_W = 64;  // divider dividend magnitude
endpackage

// ===== sv/bae_queue.sv =====
`timescale 1ns / 1ps
module bae_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         q_full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         q_empty
);
  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;

  assign q_full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== sv/bae_front.sv =====
`timescale 1ns / 1ps
module bae_front #(
  parameter int MAX_STRATA = 16,
  parameter int MAX_SAMPLES = 65536,
  parameter int SLOT_W = 4,
  parameter int USED_W = 5,
  parameter int CNT_W = 17
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [bae_pkg::LBL_W-1:0] stratum,
  input  logic                     last,
  output logic                     e_push,
  output logic [SLOT_W-1:0]        e_slot,
  output logic                     e_new,
  output logic                     e_upd,
  output logic [USED_W-1:0]        e_used,
  output logic                     e_ovf,
  output logic [CNT_W-1:0]         e_total
);
  logic [bae_pkg::LBL_W-1:0] lbl_r [MAX_STRATA];
  logic [MAX_STRATA-1:0]     vld_r;
  logic [USED_W-1:0]         used_r;
  logic [CNT_W-1:0]          total_r;
  logic                      ovf_r;

  logic              hit, cap, room, alloc;
  logic [SLOT_W-1:0] hit_idx;

  // labels are unique, so OR-ing the matching indices gives the match
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_STRATA; i++) begin
      if (vld_r[i] && lbl_r[i] == stratum) begin
        hit     = 1'b1;
        hit_idx = hit_idx | SLOT_W'(i);
      end
    end
  end

  assign cap   = (total_r >= CNT_W'(MAX_SAMPLES));
  assign room  = (used_r < USED_W'(MAX_STRATA));
  assign alloc = !cap && !hit && room;
  assign e_upd = !cap && (hit || room);
  assign e_new = alloc;
  // free entries fill from index zero upward, so the next free one is the count
  assign e_slot  = hit ? hit_idx : used_r[SLOT_W-1:0];
  assign e_used  = used_r + USED_W'(alloc);
  assign e_total = total_r + CNT_W'(e_upd);
  assign e_ovf   = ovf_r | (!cap && !hit && !room);
  assign e_push  = accept && (e_upd || last);

  always_ff @(posedge clk) begin
    if (accept && alloc) begin
      lbl_r[used_r[SLOT_W-1:0]] <= stratum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      used_r  <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (last) begin
        vld_r   <= '0;
        used_r  <= '0;
        total_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (alloc) vld_r[used_r[SLOT_W-1:0]] <= 1'b1;
        used_r  <= e_used;
        total_r <= e_total;
        ovf_r   <= e_ovf;
      end
    end
  end
endmodule

// ===== sv/bae_div.sv =====
`timescale 1ns / 1ps
module bae_div #(
  parameter int DVS_W = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bae_pkg::DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0]          dvs,
  output logic [bae_pkg::DVD_W-1:0] quo,
  output logic                      done,
  output logic                      busy
);
  localparam int DW = bae_pkg::DVD_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0]    quo_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   rsh, rsub;

  // one quotient bit a cycle, restoring
  assign rsh  = {rem_r, quo_r[DW-1]};
  assign rsub = rsh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dvd;
      rem_r <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      if (!rsub[DVS_W]) begin
        rem_r <= rsub[DVS_W-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rsh[DVS_W-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(DW-1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW-1)) busy_r <= 1'b0;
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
  assign busy = busy_r;
endmodule

// ===== sv/bae_back.sv =====
`timescale 1ns / 1ps
module bae_back #(
  parameter int MAX_STRATA = 16,
  parameter int SLOT_W = 4,
  parameter int USED_W = 5,
  parameter int CNT_W = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [SLOT_W-1:0]          e_slot,
  input  logic                       e_new,
  input  logic                       e_upd,
  input  logic                       e_last,
  input  logic [bae_pkg::TRT_W-1:0]  e_trt,
  input  logic [bae_pkg::OUTC_W-1:0] e_outc,
  input  logic [USED_W-1:0]          e_used,
  input  logic                       e_ovf,
  input  logic [CNT_W-1:0]           e_total,
  output logic                       empty,
  input  logic                       pop,
  output logic [bae_pkg::EFF_W-1:0]  effect,
  output logic [bae_pkg::SU_W-1:0]   strata_used,
  output logic                       table_full,
  output logic                       saturated
);
  localparam int WW    = bae_pkg::WOS_W;
  localparam int DW    = bae_pkg::DVD_W;
  localparam int EW    = bae_pkg::EFF_W;
  localparam int TS_W  = bae_pkg::TRT_W + CNT_W;
  localparam int PR_W  = bae_pkg::OUTC_W + bae_pkg::TRT_W;
  localparam int MUL_W = EW + CNT_W + 1;
  localparam int ACC_W = EW + USED_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_UPD, S_FST, S_FRD, S_FCHK,
    S_D1GO, S_D1W, S_MUL, S_D2GO, S_D2W, S_OUT
  } state_t;

  state_t state_r;

  // per-stratum accumulators
  logic signed [WW-1:0] wos_mem [MAX_STRATA];
  logic [TS_W-1:0]      ts_mem  [MAX_STRATA];
  logic [CNT_W-1:0]     cnt_mem [MAX_STRATA];
  logic signed [WW-1:0] rd_wos;
  logic [TS_W-1:0]      rd_ts;
  logic [CNT_W-1:0]     rd_cnt;
  logic [SLOT_W-1:0]    rd_addr;

  // current item
  logic [SLOT_W-1:0]          i_slot;
  logic                       i_new, i_upd, i_last, i_ovf;
  logic [bae_pkg::TRT_W-1:0]  i_trt;
  logic [bae_pkg::OUTC_W-1:0] i_outc;
  logic [USED_W-1:0]          i_used;
  logic [CNT_W-1:0]           i_total;

  logic signed [PR_W-1:0]  prod_r;
  logic [USED_W-1:0]       k_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    clp_r, neg_r;
  logic signed [EW-1:0]    mean_r;
  logic signed [MUL_W-1:0] mcp_r;
  logic                    out_valid_r;
  logic [EW-1:0]           eff_r;
  logic [bae_pkg::SU_W-1:0] su_r;
  logic                    tf_r, sat_r;

  // datapath
  logic signed [WW:0]      sum65;
  logic signed [WW-1:0]    wos_base, wos_nxt;
  logic [TS_W-1:0]         ts_base;
  logic [CNT_W-1:0]        cnt_base;
  logic signed [PR_W-1:0]  prod_nxt;
  logic signed [MUL_W-1:0] mcp_nxt;
  logic signed [DW-1:0]    mcp_ext;
  logic                    dv_start;
  logic [DW-1:0]           dv_dvd, dv_quo;
  logic [TS_W-1:0]         dv_dvs;
  logic                    dv_done, dv_busy;
  logic signed [DW:0]      mfull;
  logic signed [EW+1:0]    term;
  logic [EW:0]             q33;
  logic                    m_in, a_in, last_k;
  logic [USED_W+4:0]       used_x;

  assign rd_addr = (state_r == S_LOAD) ? i_slot : k_r[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    rd_wos <= wos_mem[rd_addr];
    rd_ts  <= ts_mem[rd_addr];
    rd_cnt <= cnt_mem[rd_addr];
    if (state_r == S_UPD && i_upd) begin
      wos_mem[i_slot] <= wos_nxt;
      ts_mem[i_slot]  <= ts_base + TS_W'(i_trt);
      cnt_mem[i_slot] <= cnt_base + 1'b1;
    end
  end

  // a freshly allocated stratum starts from zero, whatever the memory holds
  assign wos_base = i_new ? '0 : rd_wos;
  assign ts_base  = i_new ? '0 : rd_ts;
  assign cnt_base = i_new ? '0 : rd_cnt;
  assign prod_nxt = $signed(i_outc) * $signed({1'b0, i_trt});
  assign sum65    = {wos_base[WW-1], wos_base} + (WW+1)'(prod_r);
  always_comb begin
    if (sum65[WW] != sum65[WW-1]) begin
      wos_nxt = sum65[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      wos_nxt = sum65[WW-1:0];
    end
  end

  assign mcp_nxt = mean_r * $signed({1'b0, rd_cnt});
  assign mcp_ext = DW'(mcp_r);

  always_comb begin
    dv_start = 1'b0;
    dv_dvd   = '0;
    dv_dvs   = rd_ts;
    if (state_r == S_D1GO) begin
      dv_start = 1'b1;
      dv_dvd   = rd_wos[WW-1] ? (~rd_wos + 1'b1) : rd_wos;
    end else if (state_r == S_D2GO) begin
      dv_start = 1'b1;
      dv_dvd   = mcp_ext[DW-1] ? (~mcp_ext + 1'b1) : mcp_ext;
      dv_dvs   = TS_W'(i_total);
    end
  end

  bae_div #(.DVS_W(TS_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .dvd   (dv_dvd),
    .dvs   (dv_dvs),
    .quo   (dv_quo),
    .done  (dv_done),
    .busy  (dv_busy)
  );

  assign mfull = neg_r ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
  assign m_in  = (&mfull[DW:EW-1]) || !(|mfull[DW:EW-1]);
  assign q33   = dv_quo[EW:0];
  assign term  = neg_r ? -$signed({1'b0, q33}) : $signed({1'b0, q33});
  assign a_in  = (&acc_r[ACC_W-1:EW-1]) || !(|acc_r[ACC_W-1:EW-1]);
  assign last_k = (k_r + 1'b1 == i_used);
  assign used_x = (USED_W+5)'(i_used);
  assign q_pop  = (state_r == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      i_slot  <= e_slot;
      i_new   <= e_new;
      i_upd   <= e_upd;
      i_last  <= e_last;
      i_trt   <= e_trt;
      i_outc  <= e_outc;
      i_used  <= e_used;
      i_ovf   <= e_ovf;
      i_total <= e_total;
    end
    if (state_r == S_LOAD) prod_r <= prod_nxt;
    if (state_r == S_D1GO) neg_r <= rd_wos[WW-1];
    if (state_r == S_D2GO) neg_r <= mcp_r[MUL_W-1];
    if (state_r == S_MUL)  mcp_r <= mcp_nxt;
    if (state_r == S_D1W && dv_done) begin
      if (m_in) mean_r <= mfull[EW-1:0];
      else mean_r <= neg_r ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      acc_r       <= '0;
      clp_r       <= 1'b0;
      out_valid_r <= 1'b0;
      eff_r       <= '0;
      su_r        <= '0;
      tf_r        <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      // drop the taken beat; the final pass reloads the register itself
      if (pop && out_valid_r && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) state_r <= e_upd ? S_LOAD : S_FST;
        end
        S_LOAD: state_r <= S_UPD;
        S_UPD:  state_r <= i_last ? S_FST : S_IDLE;
        S_FST: begin
          k_r     <= '0;
          acc_r   <= '0;
          clp_r   <= 1'b0;
          state_r <= (i_used == '0) ? S_OUT : S_FRD;
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: begin
          if (rd_ts == '0 || i_total == '0) begin
            k_r     <= k_r + 1'b1;
            state_r <= last_k ? S_OUT : S_FRD;
          end else begin
            state_r <= S_D1GO;
          end
        end
        S_D1GO: state_r <= S_D1W;
        S_D1W: begin
          if (dv_done) begin
            if (!m_in) clp_r <= 1'b1;
            state_r <= S_MUL;
          end
        end
        S_MUL:  state_r <= S_D2GO;
        S_D2GO: state_r <= S_D2W;
        S_D2W: begin
          if (dv_done) begin
            acc_r   <= acc_r + ACC_W'(term);
            k_r     <= k_r + 1'b1;
            state_r <= last_k ? S_OUT : S_FRD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || pop) begin
            out_valid_r <= 1'b1;
            if (a_in) eff_r <= acc_r[EW-1:0];
            else eff_r <= acc_r[ACC_W-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            sat_r   <= clp_r | !a_in;
            su_r    <= (used_x > (USED_W+5)'(31)) ? 5'd31 : used_x[4:0];
            tf_r    <= i_ovf;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign empty       = !out_valid_r;
  assign effect      = eff_r;
  assign strata_used = su_r;
  assign table_full  = tf_r;
  assign saturated   = sat_r;

`ifndef SYNTHESIS
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FCHK) |-> (k_r < i_used))
    else $error("stratum index past the strata in use");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_LOAD || state_r == S_UPD) |-> !dv_busy)
    else $error("divider running outside the final pass");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || pop)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after the final pass");
`endif
endmodule

// ===== sv/backdoor_adjusted_effect.sv =====
`timescale 1ns / 1ps
// Backdoor-adjusted effect estimator. Samples (treatment Q8.8, outcome Q16.16,
// confounder label) enter through a push/full queue interface; the front end
// matches the label against the table of up to MAX_STRATA labels combinationally
// and hands a classified beat to a four-deep queue, so the input keeps taking
// samples while the back end works, unless the queue is full. The back end does
// a read-modify-write of the per-stratum sums in stratum memories through
// S_LOAD and S_UPD, one sample at a time. On a beat marked last it walks the
// strata in use: per stratum one divide for the mean and one for the share,
// then one result beat appears on the pop/empty side, held until taken. Table
// state clears with the last beat, and no clearing pass is needed after reset.
module backdoor_adjusted_effect #(
  parameter int MAX_STRATA = 16,
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [bae_pkg::TRT_W-1:0]  in_treatment,
  input  logic [bae_pkg::OUTC_W-1:0] in_outcome,
  input  logic [bae_pkg::LBL_W-1:0]  in_stratum,
  input  logic                       in_last,
  output logic                       empty,
  input  logic                       pop,
  output logic [bae_pkg::EFF_W-1:0]  out_effect,
  output logic [bae_pkg::SU_W-1:0]   out_strata_used,
  output logic                       out_table_full,
  output logic                       out_saturated
);
  localparam int SLOT_W = (MAX_STRATA > 1) ? $clog2(MAX_STRATA) : 1;
  localparam int USED_W = $clog2(MAX_STRATA + 1);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int TW     = bae_pkg::TRT_W;
  localparam int OW     = bae_pkg::OUTC_W;
  // queue beat: slot, new, update, last, treatment, outcome, used, overflow, total
  localparam int QW     = SLOT_W + 3 + TW + OW + USED_W + 1 + CNT_W;

  logic              accept, q_full, q_empty, q_pop, f_push;
  logic [SLOT_W-1:0] f_slot, b_slot;
  logic              f_new, f_upd, b_new, b_upd, b_last, f_ovf, b_ovf;
  logic [USED_W-1:0] f_used, b_used;
  logic [CNT_W-1:0]  f_total, b_total;
  logic [TW-1:0]     b_trt;
  logic [OW-1:0]     b_outc;
  logic [QW-1:0]     q_wr, q_rd;

  // take a sample only when the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  bae_front #(
    .MAX_STRATA (MAX_STRATA),
    .MAX_SAMPLES(MAX_SAMPLES),
    .SLOT_W     (SLOT_W),
    .USED_W     (USED_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stratum(in_stratum),
    .last   (in_last),
    .e_push (f_push),
    .e_slot (f_slot),
    .e_new  (f_new),
    .e_upd  (f_upd),
    .e_used (f_used),
    .e_ovf  (f_ovf),
    .e_total(f_total)
  );

  assign q_wr = {f_slot, f_new, f_upd, in_last, in_treatment, in_outcome,
                 f_used, f_ovf, f_total};

  bae_queue #(.W(QW)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_push),
    .wr_data(q_wr),
    .q_full (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd),
    .q_empty(q_empty)
  );

  // unpack the head beat for the back end
  assign {b_slot, b_new, b_upd, b_last, b_trt, b_outc, b_used, b_ovf, b_total} = q_rd;

  bae_back #(
    .MAX_STRATA(MAX_STRATA),
    .SLOT_W    (SLOT_W),
    .USED_W    (USED_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .e_slot     (b_slot),
    .e_new      (b_new),
    .e_upd      (b_upd),
    .e_last     (b_last),
    .e_trt      (b_trt),
    .e_outc     (b_outc),
    .e_used     (b_used),
    .e_ovf      (b_ovf),
    .e_total    (b_total),
    .empty      (empty),
    .pop        (pop),
    .effect     (out_effect),
    .strata_used(out_strata_used),
    .table_full (out_table_full),
    .saturated  (out_saturated)
  );
endmodule
